>>> design/v3alu_pkg.sv
package v3alu_pkg;

    // Width of every data port of the block.
    localparam int PORT_BITS = 32;
    localparam int OP_BITS = 3;

    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRACTION_BITS = 16;

    typedef logic [OP_BITS-1:0] t_op;

    localparam t_op OP_ADD   = 3'd0;
    localparam t_op OP_SUB   = 3'd1;
    localparam t_op OP_SCALE = 3'd2;
    localparam t_op OP_DOT   = 3'd3;
    localparam t_op OP_CROSS = 3'd4;
    localparam t_op OP_MAG   = 3'd5;
    localparam t_op OP_UNIT  = 3'd6;

endpackage

>>> design/vector3_fixed_point_alu.sv
// Pipelined three-component vector unit in signed fixed point (Q16.16 by default):
// add, subtract, scale, dot, cross, magnitude and unit vector, with saturation
// and an overflow flag, and a divide flag for the unit vector of a zero vector.
// One transaction is accepted every clock cycle while o_ready is high. The word
// is capped at 32 bits. Each result passes the front end, then the square
// root pipeline, one root bit per stage, then the divider pipeline, one
// quotient bit per stage, and last the output register; every operation takes
// the same path. When the output register holds a result that is not taken,
// the whole pipeline holds.
module vector3_fixed_point_alu #(
    parameter int WORD_BITS = v3alu_pkg::DEF_WORD_BITS,
    parameter int FRACTION_BITS = v3alu_pkg::DEF_FRACTION_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_a_x,
    input  logic [31:0] i_a_y,
    input  logic [31:0] i_a_z,
    input  logic [31:0] i_b_x,
    input  logic [31:0] i_b_y,
    input  logic [31:0] i_b_z,
    input  logic [31:0] i_scale_factor,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z,
    output logic [31:0] o_out_scalar,
    output logic        o_overflow,
    output logic        o_divide_by_zero
);

    localparam int PB = v3alu_pkg::PORT_BITS;
    localparam int W  = (WORD_BITS < PB) ? WORD_BITS : PB;
    localparam int F  = FRACTION_BITS;
    localparam int OB = v3alu_pkg::OP_BITS;
    localparam int SQ_SIDE_W = OB + 7*W + 4;
    localparam int DV_SIDE_W = OB + 4*W + 2;
    localparam int UW = W + F + 2;
    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    logic en;
    logic r_out_valid;

    assign en      = ~r_out_valid | i_ready;
    assign o_ready = en;

    // Front end: products, sums, rounding and the simple operations.
    logic              f_valid;
    v3alu_pkg::t_op    f_op;
    logic [W-1:0]      f_x, f_y, f_z, f_s;
    logic              f_ovf;
    logic [2*W-1:0]    f_n;
    logic [2:0][W-1:0] f_abs;
    logic [2:0]        f_sgn;

    v3alu_front #(
        .W (W),
        .F (F)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_op    (i_operation),
        .i_a     ({i_a_z[W-1:0], i_a_y[W-1:0], i_a_x[W-1:0]}),
        .i_b     ({i_b_z[W-1:0], i_b_y[W-1:0], i_b_x[W-1:0]}),
        .i_k     (i_scale_factor[W-1:0]),
        .o_valid (f_valid),
        .o_op    (f_op),
        .o_x     (f_x),
        .o_y     (f_y),
        .o_z     (f_z),
        .o_s     (f_s),
        .o_ovf   (f_ovf),
        .o_n     (f_n),
        .o_abs   (f_abs),
        .o_sgn   (f_sgn)
    );

    logic                 sq_valid;
    logic [W-1:0]         sq_root;
    logic [SQ_SIDE_W-1:0] sq_side;

    v3alu_sqrt #(
        .W      (W),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_n     (f_n),
        .i_side  ({f_op, f_x, f_y, f_z, f_s, f_ovf, f_abs, f_sgn}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    v3alu_pkg::t_op    s_op;
    logic [W-1:0]      s_x, s_y, s_z, s_s;
    logic              s_ovf;
    logic [2:0][W-1:0] s_abs;
    logic [2:0]        s_sgn;
    logic [W-1:0]      g_s;
    logic              g_ovf;
    logic              g_dz;

    assign {s_op, s_x, s_y, s_z, s_s, s_ovf, s_abs, s_sgn} = sq_side;

    // The root is unsigned; a magnitude with its top bit set exceeds the range.
    always_comb begin
        g_s   = s_s;
        g_ovf = s_ovf;
        if (s_op == v3alu_pkg::OP_MAG) begin
            g_s   = sq_root[W-1] ? SAT_MAX : sq_root;
            g_ovf = sq_root[W-1];
        end
        g_dz = (s_op == v3alu_pkg::OP_UNIT) && (sq_root == '0);
    end

    logic                 d_valid;
    logic [2:0][F:0]      d_q;
    logic [2:0]           d_sgn;
    logic [DV_SIDE_W-1:0] d_side;

    v3alu_div #(
        .W      (W),
        .F      (F),
        .SIDE_W (DV_SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_abs   (s_abs),
        .i_sgn   (s_sgn),
        .i_m     (sq_root),
        .i_side  ({s_op, s_x, s_y, s_z, g_s, g_ovf, g_dz}),
        .o_valid (d_valid),
        .o_q     (d_q),
        .o_sgn   (d_sgn),
        .o_side  (d_side)
    );

    v3alu_pkg::t_op d_op;
    logic [W-1:0]   d_x, d_y, d_z, d_s;
    logic           d_ovf;
    logic           d_dz;

    assign {d_op, d_x, d_y, d_z, d_s, d_ovf, d_dz} = d_side;

    // Final selection: signed unit components, saturated to the word.
    logic signed [UW-1:0] c_v[3];
    logic [W-1:0]         c_u[3];
    logic [2:0]           c_uovf;
    logic [W-1:0]         c_x, c_y, c_z, c_s;
    logic                 c_ovf;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (d_sgn[l]) begin
                c_v[l] = -$signed(UW'(d_q[l]));
            end else begin
                c_v[l] = $signed(UW'(d_q[l]));
            end
            if ((&c_v[l][UW-1:W-1]) | ~(|c_v[l][UW-1:W-1])) begin
                c_u[l]    = c_v[l][W-1:0];
                c_uovf[l] = 1'b0;
            end else begin
                c_u[l]    = c_v[l][UW-1] ? SAT_MIN : SAT_MAX;
                c_uovf[l] = 1'b1;
            end
        end
        c_x   = d_x;
        c_y   = d_y;
        c_z   = d_z;
        c_s   = d_s;
        c_ovf = d_ovf;
        if ((d_op == v3alu_pkg::OP_UNIT) && !d_dz) begin
            c_x   = c_u[0];
            c_y   = c_u[1];
            c_z   = c_u[2];
            c_ovf = |c_uovf;
        end
    end

    logic [W-1:0] r_out_x, r_out_y, r_out_z, r_out_s;
    logic         r_out_ovf;
    logic         r_out_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x   <= c_x;
            r_out_y   <= c_y;
            r_out_z   <= c_z;
            r_out_s   <= c_s;
            r_out_ovf <= c_ovf;
            r_out_dz  <= d_dz;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_out_x          = PB'($signed(r_out_x));
    assign o_out_y          = PB'($signed(r_out_y));
    assign o_out_z          = PB'($signed(r_out_z));
    assign o_out_scalar     = PB'($signed(r_out_s));
    assign o_overflow       = r_out_ovf;
    assign o_divide_by_zero = r_out_dz;

    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> (o_out_x == '0) && (o_out_y == '0) &&
        (o_out_z == '0) && (o_out_scalar == '0) && !o_overflow)
        else $error("divide flag with nonzero result or overflow");

    a_scalar_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_scalar != '0) |->
        (o_out_x == '0) && (o_out_y == '0) && (o_out_z == '0))
        else $error("scalar result together with a vector result");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

>>> design/v3alu_front.sv
module v3alu_front #(
    parameter int W = v3alu_pkg::DEF_WORD_BITS,
    parameter int F = v3alu_pkg::DEF_FRACTION_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  v3alu_pkg::t_op       i_op,
    input  logic [2:0][W-1:0]    i_a,
    input  logic [2:0][W-1:0]    i_b,
    input  logic [W-1:0]         i_k,
    output logic                 o_valid,
    output v3alu_pkg::t_op       o_op,
    output logic [W-1:0]         o_x,
    output logic [W-1:0]         o_y,
    output logic [W-1:0]         o_z,
    output logic [W-1:0]         o_s,
    output logic                 o_ovf,
    output logic [2*W-1:0]       o_n,
    output logic [2:0][W-1:0]    o_abs,
    output logic [2:0]           o_sgn
);

    localparam int TW = 2*W + 2;
    localparam logic signed [TW-1:0] ROUND_HALF = TW'(2**(F-1));
    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W:0] sat_tw(input logic signed [TW-1:0] v);
        logic fits;
        fits = (&v[TW-1:W-1]) | ~(|v[TW-1:W-1]);
        if (fits) begin
            sat_tw = {1'b0, v[W-1:0]};
        end else begin
            sat_tw = {1'b1, (v[TW-1] ? SAT_MIN : SAT_MAX)};
        end
    endfunction

    function automatic logic [W:0] sat_add(input logic signed [W:0] v);
        if (v[W] == v[W-1]) begin
            sat_add = {1'b0, v[W-1:0]};
        end else begin
            sat_add = {1'b1, (v[W] ? SAT_MIN : SAT_MAX)};
        end
    endfunction

    // Stage A: input capture.
    logic                  r_a_v;
    v3alu_pkg::t_op        r_a_op;
    logic signed [W-1:0]   r_a[3];
    logic signed [W-1:0]   r_b[3];
    logic signed [W-1:0]   r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_op <= i_op;
            r_k    <= $signed(i_k);
            for (int l = 0; l < 3; l++) begin
                r_a[l] <= $signed(i_a[l]);
                r_b[l] <= $signed(i_b[l]);
            end
        end
    end

    // Stage B: six shared multipliers, add and subtract lanes.
    logic signed [W-1:0]   c_ml[6];
    logic signed [W-1:0]   c_mr[6];
    logic signed [2*W-1:0] c_p[6];
    logic signed [W:0]     c_sum[3];
    logic [W:0]            c_addsat[3];
    logic [2:0][W-1:0]     c_abs;
    logic [2:0]            c_sgn;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            c_ml[i] = '0;
            c_mr[i] = '0;
        end
        unique case (r_a_op)
            v3alu_pkg::OP_SCALE: begin
                c_ml[0] = r_k;  c_mr[0] = r_a[0];
                c_ml[2] = r_k;  c_mr[2] = r_a[1];
                c_ml[4] = r_k;  c_mr[4] = r_a[2];
            end
            v3alu_pkg::OP_DOT: begin
                c_ml[0] = r_a[0];  c_mr[0] = r_b[0];
                c_ml[1] = r_a[1];  c_mr[1] = r_b[1];
                c_ml[2] = r_a[2];  c_mr[2] = r_b[2];
            end
            v3alu_pkg::OP_CROSS: begin
                c_ml[0] = r_a[1];  c_mr[0] = r_b[2];
                c_ml[1] = r_a[2];  c_mr[1] = r_b[1];
                c_ml[2] = r_a[2];  c_mr[2] = r_b[0];
                c_ml[3] = r_a[0];  c_mr[3] = r_b[2];
                c_ml[4] = r_a[0];  c_mr[4] = r_b[1];
                c_ml[5] = r_a[1];  c_mr[5] = r_b[0];
            end
            v3alu_pkg::OP_MAG, v3alu_pkg::OP_UNIT: begin
                for (int i = 0; i < 3; i++) begin
                    c_ml[i] = r_a[i];
                    c_mr[i] = r_a[i];
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 6; i++) begin
            c_p[i] = c_ml[i] * c_mr[i];
        end
        for (int l = 0; l < 3; l++) begin
            if (r_a_op == v3alu_pkg::OP_SUB) begin
                c_sum[l] = (W+1)'(r_a[l]) - (W+1)'(r_b[l]);
            end else begin
                c_sum[l] = (W+1)'(r_a[l]) + (W+1)'(r_b[l]);
            end
            c_addsat[l] = sat_add(c_sum[l]);
            c_sgn[l] = r_a[l][W-1];
            c_abs[l] = r_a[l][W-1] ? W'(~r_a[l] + 1'b1) : r_a[l];
        end
    end

    logic                  r_b_v;
    v3alu_pkg::t_op        r_b_op;
    logic signed [2*W-1:0] r_p[6];
    logic [2:0][W-1:0]     r_b_add;
    logic                  r_b_aovf;
    logic [2:0][W-1:0]     r_b_abs;
    logic [2:0]            r_b_sgn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_op   <= r_a_op;
            for (int i = 0; i < 6; i++) begin
                r_p[i] <= c_p[i];
            end
            for (int l = 0; l < 3; l++) begin
                r_b_add[l] <= c_addsat[l][W-1:0];
            end
            r_b_aovf <= c_addsat[0][W] | c_addsat[1][W] | c_addsat[2][W];
            r_b_abs  <= c_abs;
            r_b_sgn  <= c_sgn;
        end
    end

    // Stage C: exact sums and differences of the products plus the rounding half.
    logic signed [TW-1:0] c_t[4];
    logic [2*W-1:0]       c_n;

    always_comb begin
        c_t[0] = TW'(r_p[0]) - TW'(r_p[1]) + ROUND_HALF;
        c_t[1] = TW'(r_p[2]) - TW'(r_p[3]) + ROUND_HALF;
        c_t[2] = TW'(r_p[4]) - TW'(r_p[5]) + ROUND_HALF;
        c_t[3] = TW'(r_p[0]) + TW'(r_p[1]) + TW'(r_p[2]) + ROUND_HALF;
        // Squares are never negative, and three of them stay below 2^(2W).
        c_n = $unsigned(r_p[0]) + $unsigned(r_p[1]) + $unsigned(r_p[2]);
    end

    logic                  r_c_v;
    v3alu_pkg::t_op        r_c_op;
    logic signed [TW-1:0]  r_c_t[4];
    logic [2*W-1:0]        r_c_n;
    logic [2:0][W-1:0]     r_c_add;
    logic                  r_c_aovf;
    logic [2:0][W-1:0]     r_c_abs;
    logic [2:0]            r_c_sgn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_op   <= r_b_op;
            for (int i = 0; i < 4; i++) begin
                r_c_t[i] <= c_t[i];
            end
            r_c_n    <= c_n;
            r_c_add  <= r_b_add;
            r_c_aovf <= r_b_aovf;
            r_c_abs  <= r_b_abs;
            r_c_sgn  <= r_b_sgn;
        end
    end

    // Stage D: floor shift, saturation and selection by operation.
    logic signed [TW-1:0] c_q[4];
    logic [W:0]           c_rs[4];
    logic [W-1:0]         c_x, c_y, c_z, c_s;
    logic                 c_ovf;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            c_q[i]  = r_c_t[i] >>> F;
            c_rs[i] = sat_tw(c_q[i]);
        end
        c_x   = '0;
        c_y   = '0;
        c_z   = '0;
        c_s   = '0;
        c_ovf = 1'b0;
        unique case (r_c_op)
            v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB: begin
                c_x   = r_c_add[0];
                c_y   = r_c_add[1];
                c_z   = r_c_add[2];
                c_ovf = r_c_aovf;
            end
            v3alu_pkg::OP_SCALE, v3alu_pkg::OP_CROSS: begin
                c_x   = c_rs[0][W-1:0];
                c_y   = c_rs[1][W-1:0];
                c_z   = c_rs[2][W-1:0];
                c_ovf = c_rs[0][W] | c_rs[1][W] | c_rs[2][W];
            end
            v3alu_pkg::OP_DOT: begin
                c_s   = c_rs[3][W-1:0];
                c_ovf = c_rs[3][W];
            end
            default: begin
            end
        endcase
    end

    logic                  r_d_v;
    v3alu_pkg::t_op        r_d_op;
    logic [W-1:0]          r_d_x, r_d_y, r_d_z, r_d_s;
    logic                  r_d_ovf;
    logic [2*W-1:0]        r_d_n;
    logic [2:0][W-1:0]     r_d_abs;
    logic [2:0]            r_d_sgn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (i_en) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_op  <= r_c_op;
            r_d_x   <= c_x;
            r_d_y   <= c_y;
            r_d_z   <= c_z;
            r_d_s   <= c_s;
            r_d_ovf <= c_ovf;
            r_d_n   <= r_c_n;
            r_d_abs <= r_c_abs;
            r_d_sgn <= r_c_sgn;
        end
    end

    assign o_valid = r_d_v;
    assign o_op    = r_d_op;
    assign o_x     = r_d_x;
    assign o_y     = r_d_y;
    assign o_z     = r_d_z;
    assign o_s     = r_d_s;
    assign o_ovf   = r_d_ovf;
    assign o_n     = r_d_n;
    assign o_abs   = r_d_abs;
    assign o_sgn   = r_d_sgn;

endmodule

>>> design/v3alu_sqrt.sv
module v3alu_sqrt #(
    parameter int W = v3alu_pkg::DEF_WORD_BITS,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*W-1:0]    i_n,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [W-1:0]      o_root,
    output logic [SIDE_W-1:0] o_side
);

    // One root bit per stage, most significant first.
    logic [W+1:0]      r_rem[W-1];
    logic [2*W-1:0]    r_n[W-1];
    logic [W-1:0]      r_root[W];
    logic [SIDE_W-1:0] r_side[W];
    logic [W-1:0]      r_v;

    for (genvar s = 0; s < W; s++) begin : g_stage
        logic [W+1:0]      c_prem;
        logic [W-1:0]      c_proot;
        logic [2*W-1:0]    c_nin;
        logic [SIDE_W-1:0] c_sin;
        logic              c_vin;
        logic [W+1:0]      c_sh;
        logic [W+1:0]      c_trial;
        logic              c_ge;

        if (s == 0) begin : g_first
            assign c_prem  = '0;
            assign c_proot = '0;
            assign c_nin   = i_n;
            assign c_sin   = i_side;
            assign c_vin   = i_valid;
        end else begin : g_next
            assign c_prem  = r_rem[s-1];
            assign c_proot = r_root[s-1];
            assign c_nin   = r_n[s-1];
            assign c_sin   = r_side[s-1];
            assign c_vin   = r_v[s-1];
        end

        assign c_sh    = {c_prem[W-1:0], c_nin[2*(W-1-s)+1 -: 2]};
        assign c_trial = {c_proot, 2'b01};
        assign c_ge    = (c_sh >= c_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= c_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[s] <= {c_proot[W-2:0], c_ge};
                r_side[s] <= c_sin;
            end
        end

        if (s < W-1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= c_ge ? (c_sh - c_trial) : c_sh;
                    r_n[s]   <= c_nin;
                end
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_root  = r_root[W-1];
    assign o_side  = r_side[W-1];

endmodule

>>> design/v3alu_div.sv
module v3alu_div #(
    parameter int W = v3alu_pkg::DEF_WORD_BITS,
    parameter int F = v3alu_pkg::DEF_FRACTION_BITS,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2:0][W-1:0] i_abs,
    input  logic [2:0]        i_sgn,
    input  logic [W-1:0]      i_m,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [2:0][F:0]   o_q,
    output logic [2:0]        o_sgn,
    output logic [SIDE_W-1:0] o_side
);

    // Each lane divides |a| * 2^F by m. Since |a| <= m the quotient has F+1 bits,
    // produced one bit per stage.
    localparam int NS = F + 1;

    logic [2:0][W-1:0] r_rem[NS-1];
    logic [W-1:0]      r_m[NS-1];
    logic [2:0][F:0]   r_q[NS];
    logic [2:0]        r_sgn[NS];
    logic [SIDE_W-1:0] r_side[NS];
    logic [NS-1:0]     r_v;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [2:0][W:0]   c_sh;
        logic [2:0][W-1:0] c_nrem;
        logic [2:0][F:0]   c_pq;
        logic [2:0][F:0]   c_nq;
        logic [W-1:0]      c_m;
        logic [2:0]        c_sin_sgn;
        logic [SIDE_W-1:0] c_sin;
        logic              c_vin;

        if (s == 0) begin : g_first
            assign c_m       = i_m;
            assign c_pq      = '0;
            assign c_sin_sgn = i_sgn;
            assign c_sin     = i_side;
            assign c_vin     = i_valid;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign c_sh[l] = {1'b0, i_abs[l]};
            end
        end else begin : g_next
            assign c_m       = r_m[s-1];
            assign c_pq      = r_q[s-1];
            assign c_sin_sgn = r_sgn[s-1];
            assign c_sin     = r_side[s-1];
            assign c_vin     = r_v[s-1];
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign c_sh[l] = {r_rem[s-1][l], 1'b0};
            end
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                if (c_sh[l] >= {1'b0, c_m}) begin
                    c_nrem[l] = W'(c_sh[l] - {1'b0, c_m});
                    c_nq[l]   = {c_pq[l][F-1:0], 1'b1};
                end else begin
                    c_nrem[l] = c_sh[l][W-1:0];
                    c_nq[l]   = {c_pq[l][F-1:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= c_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s]    <= c_nq;
                r_sgn[s]  <= c_sin_sgn;
                r_side[s] <= c_sin;
            end
        end

        if (s < NS-1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= c_nrem;
                    r_m[s]   <= c_m;
                end
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_q     = r_q[NS-1];
    assign o_sgn   = r_sgn[NS-1];
    assign o_side  = r_side[NS-1];

endmodule
